// ===== hw/rtl/cpg_pkg.sv =====
package cpg_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned ColorBits = 32;
  localparam int unsigned DimBits   = 13;
  localparam int unsigned AddrBits  = 24;
  localparam int unsigned DecBits   = 18;

  localparam logic [DimBits-1:0] FbWidthReset  = DimBits'(640);
  localparam logic [DimBits-1:0] FbHeightReset = DimBits'(480);

  localparam logic [DecBits-1:0] DecStart   = DecBits'(3);
  localparam logic [DecBits-1:0] DecStepOut = DecBits'(10);
  localparam logic [DecBits-1:0] DecStepIn  = DecBits'(6);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic {
    CFG_FB_WIDTH  = 1'b0,
    CFG_FB_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [ColorBits-1:0] color_t;
  typedef logic [DimBits-1:0]   dim_t;

  typedef struct packed {
    op_e    op;
    coord_t center_x;
    coord_t center_y;
    coord_t radius;
    color_t border_color;
    color_t fill_color;
    logic   filled;
  } in_t;

  typedef struct packed {
    logic                write_enable;
    coord_t              pixel_x;
    coord_t              pixel_y;
    logic [AddrBits-1:0] pixel_address;
    color_t              color;
    logic                last;
    logic                done_res;
  } out_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t oct_a;
    coord_t oct_b;
    color_t color;
    logic   done;
  } group_t;

endpackage

// ===== hw/rtl/cpg_front.sv =====
module cpg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cpg_pkg::in_t    in_data_i,
  input  logic            full_i,
  output logic            push_o,
  output cpg_pkg::group_t push_data_o
);
  import cpg_pkg::*;

  localparam int unsigned SW = CoordBits + 2;

  coord_t ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d;
  coord_t step_x_q, step_x_d, step_y_q, step_y_d;
  coord_t fill_row_q, fill_row_d;
  logic [DecBits-1:0] dec_q, dec_d;
  color_t outline_q, outline_d, interior_q, interior_d;
  logic fill_mode_q, fill_mode_d, fill_phase_q, fill_phase_d, busy_q, busy_d;

  logic accept;
  logic signed [SW-1:0] xn, yn;
  logic dec_pos, adv_done;
  logic [DecBits-1:0] dec_adv;

  assign in_ready_o = !full_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    dec_pos = !dec_q[DecBits-1] && (dec_q != '0);
    xn = $signed({2'b00, step_x_q}) + SW'(1);
    yn = dec_pos ? $signed({2'b00, step_y_q}) - SW'(1) : $signed({2'b00, step_y_q});
    if (dec_pos) begin
      dec_adv = dec_q + (DecBits'(xn - yn) << 2) + DecStepOut;
    end else begin
      dec_adv = dec_q + (DecBits'(xn) << 2) + DecStepIn;
    end
    adv_done = yn < xn;
  end

  always_comb begin
    ctr_x_d      = ctr_x_q;
    ctr_y_d      = ctr_y_q;
    step_x_d     = step_x_q;
    step_y_d     = step_y_q;
    fill_row_d   = fill_row_q;
    dec_d        = dec_q;
    outline_d    = outline_q;
    interior_d   = interior_q;
    fill_mode_d  = fill_mode_q;
    fill_phase_d = fill_phase_q;
    busy_d       = busy_q;
    push_o       = 1'b0;

    push_data_o.center_x = ctr_x_q;
    push_data_o.center_y = ctr_y_q;
    push_data_o.oct_a    = step_x_q;
    push_data_o.oct_b    = fill_phase_q ? fill_row_q : step_y_q;
    push_data_o.color    = fill_phase_q ? interior_q : outline_q;
    push_data_o.done     = 1'b0;

    if (accept) begin
      if (in_data_i.op == OP_START) begin
        ctr_x_d      = in_data_i.center_x;
        ctr_y_d      = in_data_i.center_y;
        step_x_d     = '0;
        step_y_d     = in_data_i.radius;
        fill_row_d   = '0;
        dec_d        = DecStart - (DecBits'(in_data_i.radius) << 1);
        outline_d    = in_data_i.border_color;
        interior_d   = in_data_i.fill_color;
        fill_mode_d  = in_data_i.filled;
        fill_phase_d = 1'b0;
        busy_d       = 1'b1;
      end else if (busy_q) begin
        push_o = 1'b1;
        if (!fill_phase_q && fill_mode_q && (step_y_q > step_x_q)) begin
          fill_phase_d = 1'b1;
          fill_row_d   = step_y_q - CoordBits'(1);
        end else if (fill_phase_q && (fill_row_q > step_x_q)) begin
          fill_row_d = fill_row_q - CoordBits'(1);
        end else begin
          fill_phase_d = 1'b0;
          fill_row_d   = '0;
          step_x_d     = xn[CoordBits-1:0];
          step_y_d     = yn[CoordBits-1:0];
          dec_d        = dec_adv;
          busy_d       = !adv_done;
          push_data_o.done = adv_done;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q      <= '0;
      ctr_y_q      <= '0;
      step_x_q     <= '0;
      step_y_q     <= '0;
      fill_row_q   <= '0;
      dec_q        <= '0;
      outline_q    <= '0;
      interior_q   <= '0;
      fill_mode_q  <= 1'b0;
      fill_phase_q <= 1'b0;
      busy_q       <= 1'b0;
    end else begin
      ctr_x_q      <= ctr_x_d;
      ctr_y_q      <= ctr_y_d;
      step_x_q     <= step_x_d;
      step_y_q     <= step_y_d;
      fill_row_q   <= fill_row_d;
      dec_q        <= dec_d;
      outline_q    <= outline_d;
      interior_q   <= interior_d;
      fill_mode_q  <= fill_mode_d;
      fill_phase_q <= fill_phase_d;
      busy_q       <= busy_d;
    end
  end

endmodule

// ===== hw/rtl/cpg_fifo.sv =====
module cpg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cpg_pkg::group_t push_data_i,
  output logic            full_o,
  output logic            head_valid_o,
  output cpg_pkg::group_t head_o,
  input  logic            pop_i
);
  import cpg_pkg::*;

  group_t mem_q [2];
  logic   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic do_pop;

  assign full_o       = count_q == 2'd2;
  assign head_valid_o = count_q != 2'd0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/cpg_back.sv =====
module cpg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  cpg_pkg::group_t head_i,
  output logic            pop_o,
  input  cpg_pkg::dim_t   fb_width_i,
  input  cpg_pkg::dim_t   fb_height_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cpg_pkg::out_t   out_data_o
);
  import cpg_pkg::*;

  localparam int unsigned SW    = CoordBits + 2;
  localparam int unsigned CmpW  = (CoordBits > DimBits) ? CoordBits : DimBits;
  localparam int unsigned ProdW = (CoordBits + DimBits > AddrBits) ?
                                  (CoordBits + DimBits) : AddrBits;

  logic [2:0] k_q, k_d;
  logic a_valid_q, a_valid_d, a_ok_q, a_last_q, a_done_q;
  coord_t a_px_q, a_py_q;
  color_t a_color_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;

  logic a_take, b_take;
  coord_t ua, ub;
  logic signed [SW-1:0] px, py;
  logic ok;
  logic [ProdW-1:0] prod;

  assign b_take = !out_valid_q || out_ready_i;
  assign a_take = !a_valid_q || b_take;
  assign pop_o  = head_valid_i && a_take && (k_q == 3'd7);

  always_comb begin
    ua = k_q[2] ? head_i.oct_b : head_i.oct_a;
    ub = k_q[2] ? head_i.oct_a : head_i.oct_b;
    px = k_q[0] ? $signed({2'b00, head_i.center_x}) - $signed({2'b00, ua})
                : $signed({2'b00, head_i.center_x}) + $signed({2'b00, ua});
    py = k_q[1] ? $signed({2'b00, head_i.center_y}) - $signed({2'b00, ub})
                : $signed({2'b00, head_i.center_y}) + $signed({2'b00, ub});
    ok = !px[SW-1] && !px[SW-2] && !py[SW-1] && !py[SW-2] &&
         (CmpW'(px[CoordBits-1:0]) < CmpW'(fb_width_i)) &&
         (CmpW'(py[CoordBits-1:0]) < CmpW'(fb_height_i));
    a_valid_d   = a_take ? head_valid_i : a_valid_q;
    k_d         = (a_take && head_valid_i) ? k_q + 3'd1 : k_q;
    out_valid_d = b_take ? a_valid_q : out_valid_q;
    prod        = ProdW'(a_py_q) * ProdW'(fb_width_i) + ProdW'(a_px_q);
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      a_px_q    <= px[CoordBits-1:0];
      a_py_q    <= py[CoordBits-1:0];
      a_ok_q    <= ok;
      a_color_q <= head_i.color;
      a_last_q  <= k_q == 3'd7;
      a_done_q  <= head_i.done;
    end
    if (b_take) begin
      out_q.write_enable  <= a_ok_q;
      out_q.pixel_x       <= a_ok_q ? a_px_q : '0;
      out_q.pixel_y       <= a_ok_q ? a_py_q : '0;
      out_q.pixel_address <= a_ok_q ? prod[AddrBits-1:0] : '0;
      out_q.color         <= a_color_q;
      out_q.last          <= a_last_q;
      out_q.done_res      <= a_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 3'd0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/circle_pixel_generator_unit.sv =====
// A step item's points pass the queue, the stage A registers and the output register, then
// leave one per cycle while out_ready_i allows, eight per step item through the single pixel
// output port; start items emit nothing. A two-entry queue lets the front take items meanwhile.
// Reset: asynchronous, active low; the block goes idle with no circle running and the
// framebuffer registers at 640 by 480.
module circle_pixel_generator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpg_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpg_pkg::out_t     out_data_o,
  input  logic              cfg_we_i,
  input  cpg_pkg::cfg_idx_e cfg_idx_i,
  input  cpg_pkg::dim_t     cfg_data_i
);
  import cpg_pkg::*;

  dim_t   fb_width_q, fb_height_q;
  logic   push, full, head_valid, pop;
  group_t push_data, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q  <= FbWidthReset;
      fb_height_q <= FbHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FB_WIDTH:  fb_width_q  <= cfg_data_i;
        CFG_FB_HEIGHT: fb_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cpg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cpg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  cpg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .fb_width_i   (fb_width_q),
    .fb_height_i  (fb_height_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== tb/tb_circle_pixel_generator_unit.sv =====
`timescale 1ns / 100ps

module tb_circle_pixel_generator_unit;
  import cpg_pkg::*;

  localparam int CycleLimit = 500_000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_t       in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_t      out_data_o;
  logic      cfg_we_i    = 1'b0;
  cfg_idx_e  cfg_idx_i   = CFG_FB_WIDTH;
  dim_t      cfg_data_i  = '0;

  circle_pixel_generator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Rasterizer state as the block should hold it.
  dim_t                      fb_w         = FbWidthReset;
  dim_t                      fb_h         = FbHeightReset;
  coord_t                    cir_cx       = '0;
  coord_t                    cir_cy       = '0;
  coord_t                    oct_x        = '0;
  coord_t                    oct_y        = '0;
  coord_t                    fill_b       = '0;
  logic signed [DecBits-1:0] dec_val      = '0;
  color_t                    outline_col  = '0;
  color_t                    interior_col = '0;
  logic                      fill_on      = 1'b0;
  logic                      filling      = 1'b0;
  logic                      running      = 1'b0;

  out_t group_pts [8];
  out_t exp_points [$];

  typedef struct {
    in_t  item;
    int   n_typed;
    out_t pt;
  } row_t;
  row_t plan [$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int ready_mode  = 0;
  int ready_left  = 0;
  int ready_phase = 0;

  function automatic out_t make_point(int px, int py, color_t col);
    out_t   p;
    longint lin;
    p = '0;
    p.color = col;
    if (px >= 0 && py >= 0 && px < int'(fb_w) && py < int'(fb_h) &&
        px < (1 << CoordBits) && py < (1 << CoordBits)) begin
      lin = longint'(py) * longint'(fb_w) + longint'(px);
      p.write_enable  = 1'b1;
      p.pixel_x       = CoordBits'(px);
      p.pixel_y       = CoordBits'(py);
      p.pixel_address = AddrBits'(lin);
    end
    return p;
  endfunction

  function automatic void build_group(int a, int b, color_t col);
    int cx;
    int cy;
    cx = int'(cir_cx);
    cy = int'(cir_cy);
    group_pts[0] = make_point(cx + a, cy + b, col);
    group_pts[1] = make_point(cx - a, cy + b, col);
    group_pts[2] = make_point(cx + a, cy - b, col);
    group_pts[3] = make_point(cx - a, cy - b, col);
    group_pts[4] = make_point(cx + b, cy + a, col);
    group_pts[5] = make_point(cx - b, cy + a, col);
    group_pts[6] = make_point(cx + b, cy - a, col);
    group_pts[7] = make_point(cx - b, cy - a, col);
    group_pts[7].last = 1'b1;
  endfunction

  function automatic bit advance_column();
    int x;
    int y;
    int d;
    x = int'(oct_x) + 1;
    y = int'(oct_y);
    d = int'(dec_val);
    if (d > 0) begin
      y = y - 1;
      d = d + 4 * (x - y) + 10;
    end else begin
      d = d + 4 * x + 6;
    end
    dec_val = DecBits'(d);
    oct_x   = CoordBits'(x);
    oct_y   = CoordBits'(y);
    return y < x;
  endfunction

  // Applies one accepted item and returns how many points it produces.
  function automatic int predict_transfer(in_t it);
    bit fin;
    fin = 1'b0;
    if (it.op == OP_START) begin
      cir_cx       = it.center_x;
      cir_cy       = it.center_y;
      oct_x        = '0;
      oct_y        = it.radius;
      fill_b       = '0;
      dec_val      = DecBits'(3 - 2 * int'(it.radius));
      outline_col  = it.border_color;
      interior_col = it.fill_color;
      fill_on      = it.filled;
      filling      = 1'b0;
      running      = 1'b1;
      return 0;
    end
    if (!running) begin
      return 0;
    end
    if (!filling) begin
      build_group(int'(oct_x), int'(oct_y), outline_col);
      if (fill_on && oct_y >= 1 && int'(oct_y) - 1 >= int'(oct_x)) begin
        filling = 1'b1;
        fill_b  = oct_y - 1'b1;
      end else begin
        fin = advance_column();
      end
    end else begin
      build_group(int'(oct_x), int'(fill_b), interior_col);
      if (fill_b == 0 || int'(fill_b) - 1 < int'(oct_x)) begin
        filling = 1'b0;
        fill_b  = '0;
        fin     = advance_column();
      end else begin
        fill_b = fill_b - 1'b1;
      end
    end
    if (fin) begin
      running = 1'b0;
      for (int k = 0; k < 8; k++) begin
        group_pts[k].done_res = 1'b1;
      end
    end
    return 8;
  endfunction

  function automatic void queue_group(int n);
    for (int k = 0; k < n; k++) begin
      exp_points.push_back(group_pts[k]);
    end
  endfunction

  function automatic in_t mk_in(op_e op, int cx, int cy, int r, color_t bc, color_t fc,
                                bit fl);
    in_t it;
    it.op           = op;
    it.center_x     = CoordBits'(cx);
    it.center_y     = CoordBits'(cy);
    it.radius       = CoordBits'(r);
    it.border_color = bc;
    it.fill_color   = fc;
    it.filled       = fl;
    return it;
  endfunction

  function automatic out_t mk_point(bit we, int px, int py, int addr, color_t col, bit fin);
    out_t p;
    p               = '0;
    p.write_enable  = we;
    p.pixel_x       = CoordBits'(px);
    p.pixel_y       = CoordBits'(py);
    p.pixel_address = AddrBits'(addr);
    p.color         = col;
    p.done_res      = fin;
    return p;
  endfunction

  function automatic void add_row(in_t it, int n, out_t pt);
    row_t r;
    r.item    = it;
    r.n_typed = n;
    r.pt      = pt;
    plan.push_back(r);
  endfunction

  function automatic coord_t pick_center(dim_t lim);
    int sel;
    int hi;
    sel = $urandom_range(0, 9);
    hi  = (lim > (1 << CoordBits)) ? (1 << CoordBits) - 1 : int'(lim) - 1;
    if (sel < 6 && hi >= 0) begin
      return CoordBits'($urandom_range(0, hi));
    end else if (sel < 8) begin
      return CoordBits'($urandom);
    end else if (sel == 8) begin
      return '0;
    end
    return '1;
  endfunction

  function automatic in_t rand_item(op_e op);
    in_t it;
    int  sel;
    it.op       = op;
    it.center_x = pick_center(fb_w);
    it.center_y = pick_center(fb_h);
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      it.radius = CoordBits'($urandom_range(0, 10));
    end else if (sel == 8) begin
      it.radius = CoordBits'($urandom);
    end else begin
      it.radius = '1;
    end
    it.border_color = $urandom;
    it.fill_color   = $urandom;
    it.filled       = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(in_t it);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left = burst_left - 1;
  endtask

  task automatic send_predicted(in_t it);
    send_item(it);
    queue_group(predict_transfer(it));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (exp_points.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_framebuffer(dim_t w, dim_t h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FB_WIDTH;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_FB_HEIGHT;
    cfg_data_i <= h;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    fb_w = w;
    fb_h = h;
  endtask

  // Mostly complete circles with random content; some are cut short by a new
  // start, and a few stray steps arrive, whether or not a circle is running.
  task automatic random_circles(int quota);
    int  taken;
    int  steps_left;
    in_t it;
    taken = 0;
    while (taken < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        if (running) begin
          taken++;
        end
        send_predicted(rand_item(OP_STEP));
      end else begin
        it = rand_item(OP_START);
        if (it.radius > 10) begin
          steps_left = $urandom_range(1, 12);
        end else begin
          steps_left = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 2000;
        end
        send_predicted(it);
        taken++;
        while (running && steps_left > 0) begin
          send_predicted(rand_item(OP_STEP));
          taken++;
          steps_left--;
        end
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [95:0] got, logic [95:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 4);
      ready_left = $urandom_range(10, 150);
    end
    ready_left--;
    ready_phase++;
    case (ready_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready_i <= ($urandom_range(0, 3) == 0);
      end
      3: begin
        out_ready_i <= (ready_phase % 5 != 0);
      end
      default: begin
        out_ready_i <= (ready_phase % 8 == 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (exp_points.size() == 0) begin
        report_mismatch("unexpected point transfer", 96'(got), '0);
      end else begin
        want = exp_points.pop_front();
        if (got.write_enable !== want.write_enable) begin
          report_mismatch("write_enable", 96'(got.write_enable), 96'(want.write_enable));
        end
        if (got.pixel_x !== want.pixel_x) begin
          report_mismatch("pixel_x", 96'(got.pixel_x), 96'(want.pixel_x));
        end
        if (got.pixel_y !== want.pixel_y) begin
          report_mismatch("pixel_y", 96'(got.pixel_y), 96'(want.pixel_y));
        end
        if (got.pixel_address !== want.pixel_address) begin
          report_mismatch("pixel_address", 96'(got.pixel_address), 96'(want.pixel_address));
        end
        if (got.color !== want.color) begin
          report_mismatch("color", 96'(got.color), 96'(want.color));
        end
        if (got.last !== want.last) begin
          report_mismatch("last", 96'(got.last), 96'(want.last));
        end
        if (got.done_res !== want.done_res) begin
          report_mismatch("done_res", 96'(got.done_res), 96'(want.done_res));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("circle_pixel_generator_unit verification failed");
      $finish;
    end
  end

  initial begin
    int   n;
    out_t pt;
    dim_t w;
    dim_t h;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), 0, '0);
    add_row(mk_in(OP_START, 100, 50, 0, 32'hFFFF_FFFF, '0, 1'b0), 0, '0);
    add_row(mk_in(OP_STEP, 4095, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 8,
            mk_point(1'b1, 100, 50, 32100, 32'hFFFF_FFFF, 1'b1));
    add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), 0, '0);
    add_row(mk_in(OP_START, 639, 479, 0, '0, 32'hFFFF_FFFF, 1'b1), 0, '0);
    add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), 8,
            mk_point(1'b1, 639, 479, 307199, '0, 1'b1));
    add_row(mk_in(OP_START, 0, 0, 5, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1), -1, '0);
    for (int k = 0; k < 5; k++) begin
      add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), -1, '0);
    end
    add_row(mk_in(OP_START, 4095, 4095, 4095, 32'h1234_5678, 32'h8765_4321, 1'b0), 0, '0);
    add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), 8,
            mk_point(1'b0, 0, 0, 0, 32'h1234_5678, 1'b0));
    add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), -1, '0);
    add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), -1, '0);
    add_row(mk_in(OP_START, 320, 240, 12, 32'hC0FF_EE00, '0, 1'b0), -1, '0);
    for (int k = 0; k < 4; k++) begin
      add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), -1, '0);
    end
    add_row(mk_in(OP_START, 320, 240, 3, 32'h0000_0001, 32'h8000_0000, 1'b1), -1, '0);
    for (int k = 0; k < 3; k++) begin
      add_row(mk_in(OP_STEP, 0, 0, 0, '0, '0, 1'b0), -1, '0);
    end

    foreach (plan[i]) begin
      send_item(plan[i].item);
      n = predict_transfer(plan[i].item);
      if (plan[i].n_typed < 0) begin
        queue_group(n);
      end else begin
        for (int k = 0; k < plan[i].n_typed; k++) begin
          pt = plan[i].pt;
          pt.last = (k == 7);
          exp_points.push_back(pt);
        end
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          w = FbWidthReset;
          h = FbHeightReset;
        end
        1: begin
          w = 1;
          h = 1;
        end
        2: begin
          w = 4096;
          h = 4096;
        end
        3: begin
          w = 0;
          h = 480;
        end
        4: begin
          w = '1;
          h = '1;
        end
        5: begin
          w = 300;
          h = 0;
        end
        default: begin
          w = DimBits'($urandom_range(1, 200));
          h = DimBits'($urandom_range(1, 200));
        end
      endcase
      wait_idle();
      set_framebuffer(w, h);
      random_circles(32);
    end

    wait_idle();
    if (error_count == 0) begin
      $display("circle_pixel_generator_unit verification clean");
    end else begin
      $display("circle_pixel_generator_unit verification failed");
    end
    $finish;
  end

endmodule
